// File: src/delayed_message_expiry_queue_top_macros.svh
// Assertion macros for the delayed message expiry queue.
// Used by the top level only; needs nothing else.
`ifndef DELAYED_MESSAGE_EXPIRY_QUEUE_TOP_MACROS_SVH
`define DELAYED_MESSAGE_EXPIRY_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define DMEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DMEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dmeq_pkg.sv
// Shared types and constants of the delayed message expiry queue.
// No dependencies.
package dmeq_pkg;

    localparam int unsigned EXP_W        = 32;
    localparam int unsigned PAY_W        = 19;
    localparam int unsigned ENTRY_W      = EXP_W + PAY_W;
    localparam int unsigned INC_W        = 10;
    localparam int unsigned RESULT_LIMIT = 32;
    localparam int unsigned N_W          = $clog2(RESULT_LIMIT + 1);

    localparam logic [INC_W-1:0] TICK_RESET = 10'd30;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [1:0] STAT_ENQUEUED = 2'd0;
    localparam logic [1:0] STAT_DROPPED  = 2'd1;
    localparam logic [1:0] STAT_RELEASED = 2'd2;

    localparam logic [2:0] REG_ADDR_TICK_INC = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_RESP,
        ST_TK_RD,
        ST_TK_CMP,
        ST_TK_FLUSH
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [7:0] handle;
        logic [3:0] sender;
        logic [3:0] receiver;
        logic       preempt;
        logic       last;
    } emit_t;

    typedef struct packed {
        logic ready;
        logic full;
        logic empty;
    } ctrl_status_t;

endpackage

// File: src/dmeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmeq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/dmeq_ctrl.sv
// Sequencer of the expiry queue: sorted insert and expiry release over a
// circular buffer in RAM, sharing one expiry comparator. Uses dmeq_pkg, dmeq_ram.
module dmeq_ctrl #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    input  logic                        req_op,
    input  logic [31:0]                 req_expiry,
    input  logic [7:0]                  req_handle,
    input  logic [3:0]                  req_sender,
    input  logic [3:0]                  req_receiver,
    input  logic [2:0]                  req_rcv_pri,
    input  logic [2:0]                  req_cur_pri,
    input  logic [dmeq_pkg::INC_W-1:0]  tick_inc,
    input  logic                        out_free,
    output dmeq_pkg::emit_t             emit,
    output dmeq_pkg::ctrl_status_t      status
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned NW = dmeq_pkg::N_W;
    localparam int unsigned EW = dmeq_pkg::ENTRY_W;
    localparam int unsigned PW = dmeq_pkg::PAY_W;

    dmeq_pkg::state_t state_reg, state_next;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [NW-1:0] n_reg, n_next;
    logic [31:0]   ms_reg, ms_next;
    logic [31:0]   exp_reg, exp_next;
    logic [PW-1:0] pay_reg, pay_next;
    logic [2:0]    cur_pri_reg, cur_pri_next;
    logic          drop_reg, drop_next;
    logic          pre_reg, pre_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [15:0]   pend_pay_reg, pend_pay_next;
    logic          pend_pre_reg, pend_pre_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, rd_data;
    logic [31:0]   rd_exp, cmp_b;
    logic          cmp_le, accept, full, empty, more, pflag;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lidx);
        logic [AW:0] sum;
        sum = {1'b0, head} + (AW+1)'(lidx);
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    dmeq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared comparator
    assign rd_exp = rd_data[EW-1:PW];
    assign cmp_b  = (state_reg == dmeq_pkg::ST_TK_CMP) ? ms_reg : exp_reg;
    assign cmp_le = (rd_exp <= cmp_b);

    assign accept = req_valid && (state_reg == dmeq_pkg::ST_IDLE);
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign more   = !empty && (n_reg < NW'(dmeq_pkg::RESULT_LIMIT));
    assign pflag  = pre_reg || (rd_data[PW-1:16] <= cur_pri_reg);

    assign status.ready = (state_reg == dmeq_pkg::ST_IDLE);
    assign status.full  = full;
    assign status.empty = empty;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dmeq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (req_op == dmeq_pkg::OP_TICK) begin
                        state_next = dmeq_pkg::ST_TK_RD;
                    end else if (full) begin
                        state_next = dmeq_pkg::ST_RESP;
                    end else begin
                        state_next = dmeq_pkg::ST_INS_RD;
                    end
                end
            end
            dmeq_pkg::ST_INS_RD: begin
                state_next = (idx_reg == '0) ? dmeq_pkg::ST_RESP : dmeq_pkg::ST_INS_CMP;
            end
            dmeq_pkg::ST_INS_CMP: begin
                state_next = cmp_le ? dmeq_pkg::ST_RESP : dmeq_pkg::ST_INS_RD;
            end
            dmeq_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = dmeq_pkg::ST_IDLE;
                end
            end
            dmeq_pkg::ST_TK_RD: begin
                state_next = more ? dmeq_pkg::ST_TK_CMP : dmeq_pkg::ST_TK_FLUSH;
            end
            dmeq_pkg::ST_TK_CMP: begin
                if (!cmp_le) begin
                    state_next = dmeq_pkg::ST_TK_FLUSH;
                end else if (!pend_valid_reg || out_free) begin
                    state_next = dmeq_pkg::ST_TK_RD;
                end
            end
            dmeq_pkg::ST_TK_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = dmeq_pkg::ST_IDLE;
                end
            end
            default: state_next = dmeq_pkg::ST_IDLE;
        endcase
    end

    // RAM ports and result requests
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = phys(head_reg, idx_reg);
        wr_data = {exp_reg, pay_reg};
        rd_en   = 1'b0;
        rd_addr = phys(head_reg, idx_reg - CW'(1));
        emit    = '0;
        case (state_reg)
            dmeq_pkg::ST_INS_RD: begin
                if (idx_reg == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en = 1'b1;
                end
            end
            dmeq_pkg::ST_INS_CMP: begin
                wr_en = 1'b1;
                if (!cmp_le) begin
                    wr_data = rd_data;
                end
            end
            dmeq_pkg::ST_RESP: begin
                emit.valid  = out_free;
                emit.status = drop_reg ? dmeq_pkg::STAT_DROPPED : dmeq_pkg::STAT_ENQUEUED;
                emit.last   = 1'b1;
            end
            dmeq_pkg::ST_TK_RD: begin
                rd_en   = more;
                rd_addr = head_reg;
            end
            dmeq_pkg::ST_TK_CMP, dmeq_pkg::ST_TK_FLUSH: begin
                emit.valid    = pend_valid_reg && out_free &&
                                ((state_reg == dmeq_pkg::ST_TK_FLUSH) || cmp_le);
                emit.status   = dmeq_pkg::STAT_RELEASED;
                emit.handle   = pend_pay_reg[7:0];
                emit.sender   = pend_pay_reg[11:8];
                emit.receiver = pend_pay_reg[15:12];
                emit.preempt  = pend_pre_reg;
                emit.last     = (state_reg == dmeq_pkg::ST_TK_FLUSH);
            end
            default: ;
        endcase
    end

    always_comb begin
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        ms_next         = ms_reg;
        exp_next        = exp_reg;
        pay_next        = pay_reg;
        cur_pri_next    = cur_pri_reg;
        drop_next       = drop_reg;
        pre_next        = pre_reg;
        pend_valid_next = pend_valid_reg;
        pend_pay_next   = pend_pay_reg;
        pend_pre_next   = pend_pre_reg;
        case (state_reg)
            dmeq_pkg::ST_IDLE: begin
                if (accept) begin
                    exp_next     = req_expiry;
                    pay_next     = {req_rcv_pri, req_receiver, req_sender, req_handle};
                    cur_pri_next = req_cur_pri;
                    drop_next    = full;
                    idx_next     = count_reg;
                    if (req_op == dmeq_pkg::OP_TICK) begin
                        ms_next         = ms_reg + 32'(tick_inc);
                        pre_next        = 1'b0;
                        pend_valid_next = 1'b0;
                        n_next          = '0;
                    end
                end
            end
            dmeq_pkg::ST_INS_RD: begin
                if (idx_reg == '0) begin
                    count_next = count_reg + CW'(1);
                end
            end
            dmeq_pkg::ST_INS_CMP: begin
                if (cmp_le) begin
                    count_next = count_reg + CW'(1);
                end else begin
                    idx_next = idx_reg - CW'(1);
                end
            end
            dmeq_pkg::ST_TK_CMP: begin
                if (cmp_le && (!pend_valid_reg || out_free)) begin
                    pend_valid_next = 1'b1;
                    pend_pay_next   = rd_data[15:0];
                    pend_pre_next   = pflag;
                    pre_next        = pflag;
                    head_next       = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                    count_next      = count_reg - CW'(1);
                    n_next          = n_reg + NW'(1);
                end
            end
            dmeq_pkg::ST_TK_FLUSH: begin
                if (out_free) begin
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dmeq_pkg::ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            ms_reg         <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            ms_reg         <= ms_next;
            pend_valid_reg <= pend_valid_next;
        end
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        exp_reg      <= exp_next;
        pay_reg      <= pay_next;
        cur_pri_reg  <= cur_pri_next;
        drop_reg     <= drop_next;
        pre_reg      <= pre_next;
        pend_pay_reg <= pend_pay_next;
        pend_pre_reg <= pend_pre_next;
    end

endmodule

// File: src/delayed_message_expiry_queue_top.sv
// Enqueue: each entry later than the new one is shifted up one place; then ready.
// Tick: releases head entries until one is unexpired, the queue is empty or the limit is hit;
// the shared comparator and the single RAM port, with its registered read, set its pace.
// Synchronous active-low reset: counter 0, queue empty, tick increment 30.
// The RAM needs no clearing pass; nothing is read before it is written.
// Top level: tick register, result register, sequencer. Uses dmeq_pkg, dmeq_ctrl.
`include "delayed_message_expiry_queue_top_macros.svh"

module delayed_message_expiry_queue_top #(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_expiry,
    input  logic [7:0]  s_msg_handle,
    input  logic [3:0]  s_sender_id,
    input  logic [3:0]  s_receiver_id,
    input  logic [2:0]  s_receiver_priority,
    input  logic [2:0]  s_current_priority,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_out_handle,
    output logic [3:0]  m_out_sender,
    output logic [3:0]  m_out_receiver,
    output logic        m_preempt_request,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [dmeq_pkg::INC_W-1:0] tick_inc_reg, tick_inc_next;
    logic                       m_valid_reg, m_valid_next;
    dmeq_pkg::emit_t            res_reg, res_next;
    dmeq_pkg::emit_t            emit;
    dmeq_pkg::ctrl_status_t     ctrl_status;
    logic                       out_free;
    logic                       req_acc, drop_acc;

    assign pready = 1'b1;

    always_comb begin
        tick_inc_next = tick_inc_reg;
        if (psel && penable && pwrite && (paddr == dmeq_pkg::REG_ADDR_TICK_INC)) begin
            tick_inc_next = pwdata[dmeq_pkg::INC_W-1:0];
        end
    end

    assign prdata = (paddr == dmeq_pkg::REG_ADDR_TICK_INC) ?
                    {{(32 - dmeq_pkg::INC_W){1'b0}}, tick_inc_reg} : '0;

    dmeq_ctrl #(.DEPTH(QUEUE_DEPTH)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_valid),
        .req_op       (s_op),
        .req_expiry   (s_expiry),
        .req_handle   (s_msg_handle),
        .req_sender   (s_sender_id),
        .req_receiver (s_receiver_id),
        .req_rcv_pri  (s_receiver_priority),
        .req_cur_pri  (s_current_priority),
        .tick_inc     (tick_inc_reg),
        .out_free     (out_free),
        .emit         (emit),
        .status       (ctrl_status)
    );

    assign s_ready  = ctrl_status.ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        res_next     = res_reg;
        if (emit.valid) begin
            m_valid_next = 1'b1;
            res_next     = emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_inc_reg <= dmeq_pkg::TICK_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            tick_inc_reg <= tick_inc_next;
            m_valid_reg  <= m_valid_next;
        end
        res_reg <= res_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = res_reg.status;
    assign m_out_handle      = res_reg.handle;
    assign m_out_sender      = res_reg.sender;
    assign m_out_receiver    = res_reg.receiver;
    assign m_preempt_request = res_reg.preempt;
    assign m_last            = res_reg.last;

    assign req_acc  = s_valid && s_ready;
    assign drop_acc = req_acc && (s_op == dmeq_pkg::OP_ENQUEUE) && ctrl_status.full;

    `DMEQ_ASSERT_IMP(a_emit_room, aclk, aresetn, emit.valid, out_free, "result overrun")
    `DMEQ_ASSERT_NXT(a_busy, aclk, aresetn, req_acc, !ctrl_status.ready, "still ready")
    `DMEQ_ASSERT_NXT(a_full_drop, aclk, aresetn, drop_acc, ctrl_status.full, "full queue changed")

endmodule
